// ----- rtl/core/mme_pkg.sv -----
// Shared types, constants and arithmetic helpers of the matrix multiply engine.
package mme_pkg;

    localparam int MAX_DIM   = 8;
    localparam int ELEM_W    = 16;
    localparam int DIM_W     = $clog2(MAX_DIM);
    localparam int ADDR_W    = 2 * DIM_W;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int FRAC_W    = ELEM_W / 2;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int ACC_W     = PROD_W + DIM_W;
    localparam int CFG_W     = 4;
    localparam int DRAIN_CYC = MAX_DIM + 2;
    localparam int DRAIN_W   = $clog2(DRAIN_CYC);

    typedef enum logic [1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_UNUSED  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_A_ROWS = 2'd0,
        REG_A_COLS = 2'd1,
        REG_B_ROWS = 2'd2,
        REG_B_COLS = 2'd3
    } t_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FEED,
        S_DRAIN,
        S_OUT,
        S_ERR
    } t_state;

    // One element of A travelling down the row of cells.
    typedef struct packed {
        logic                     valid;
        logic                     first;
        logic [DIM_W-1:0]         k;
        logic signed [ELEM_W-1:0] a;
    } t_tok;

    typedef struct packed {
        logic                     sat;
        logic signed [ELEM_W-1:0] val;
    } t_res;

    // Register value 0 acts as 1, anything above MAX_DIM as MAX_DIM.
    function automatic logic [DIM_W:0] eff_dim(input logic [CFG_W-1:0] r);
        logic [DIM_W:0] d;
        if (r == '0) begin
            d = (DIM_W+1)'(1);
        end else if (32'(r) > MAX_DIM) begin
            d = (DIM_W+1)'(MAX_DIM);
        end else begin
            d = (DIM_W+1)'(r);
        end
        return d;
    endfunction

    // Round half up back to Q8.8, then clip to the element range.
    function automatic t_res round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-1:0] q;
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        t_res res;
        t  = acc + ACC_W'(1 << (FRAC_W - 1));
        q  = t >>> FRAC_W;
        hi = ACC_W'((1 << (ELEM_W - 1)) - 1);
        lo = -hi - ACC_W'(1);
        if (q > hi) begin
            res.sat = 1'b1;
            res.val = hi[ELEM_W-1:0];
        end else if (q < lo) begin
            res.sat = 1'b1;
            res.val = lo[ELEM_W-1:0];
        end else begin
            res.sat = 1'b0;
            res.val = q[ELEM_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/mme_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/mme_cell.sv -----
// One multiply-accumulate cell holding a column of B.
module mme_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mme_pkg::t_tok                    i_tok,
    output mme_pkg::t_tok                    o_tok,
    input  logic                             i_we,
    input  logic [mme_pkg::DIM_W-1:0]        i_waddr,
    input  logic signed [mme_pkg::ELEM_W-1:0] i_wdata,
    output logic signed [mme_pkg::ACC_W-1:0] o_acc
);
    import mme_pkg::*;

    logic signed [ELEM_W-1:0] r_col [MAX_DIM];
    t_tok                     r_tok;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pvalid;
    logic                     r_pfirst;
    logic signed [ACC_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_col[i_waddr] <= i_wdata;
        end
        r_prod   <= i_tok.a * r_col[i_tok.k];
        r_pfirst <= i_tok.first;
        if (r_pvalid) begin
            if (r_pfirst) begin
                r_acc <= ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok    <= '0;
            r_pvalid <= 1'b0;
        end else begin
            r_tok    <= i_tok;
            r_pvalid <= i_tok.valid;
        end
    end

    assign o_tok = r_tok;
    assign o_acc = r_acc;
endmodule

// ----- rtl/core/matrix_multiply_engine.sv -----
// Top level of the matrix multiply engine: stores, sequencer and cell row.
//
// Each load item writes one A or B element. A compute item streams each row of
// A from a RAM down a row of MAX_DIM cells, one element per cycle; cell j holds
// column j of B and accumulates C[i][j]. Each row is fed a_cols elements, the
// cell row then drains, and the b_cols results of the row are sent whenever the
// output register is free. New items are taken only while the sequencer is
// idle; the last result may still wait in the output register. A size mismatch
// gives a single error transfer with tlast set.
module matrix_multiply_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // row[2:0], col[5:3], value[21:6], zero pad
    input  logic [1:0]  i_s_axis_tuser,  // operation[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // out_row[2:0], out_col[5:3], product[21:6], zero pad
    output logic        o_m_axis_tlast,
    output logic [1:0]  o_m_axis_tuser,  // size_error[0], saturated[1]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mme_pkg::*;

    t_state r_state, n_state;
    logic [DIM_W-1:0] r_i, n_i, r_k, n_k, r_j, n_j;
    logic [DRAIN_W-1:0] r_drain, n_drain;
    logic r_fvalid, n_fvalid, r_ffirst, n_ffirst;
    logic [DIM_W-1:0] r_fk, n_fk;
    logic [CFG_W-1:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;

    logic r_ov, n_ov;
    logic [DIM_W-1:0] r_orow, n_orow, r_ocol, n_ocol;
    logic signed [ELEM_W-1:0] r_oprod, n_oprod;
    logic r_olast, n_olast, r_oerr, n_oerr, r_osat, n_osat;

    logic [DIM_W-1:0] w_row, w_col, w_ar_m1, w_ac_m1, w_bc_m1;
    logic signed [ELEM_W-1:0] w_value;
    t_op w_op;
    logic w_accept, w_ram_we, w_load_b, w_cfg_we;
    logic [ADDR_W-1:0] w_raddr;
    logic [ELEM_W-1:0] w_rdata;
    logic [DIM_W:0] w_ac, w_br;
    t_tok w_tok [MAX_DIM+1];
    logic signed [ACC_W-1:0] w_acc [MAX_DIM];
    t_res w_res;
    logic w_out_free;

    assign w_row    = i_s_axis_tdata[DIM_W-1:0];
    assign w_col    = i_s_axis_tdata[2*DIM_W-1:DIM_W];
    assign w_value  = i_s_axis_tdata[2*DIM_W+ELEM_W-1:2*DIM_W];
    assign w_op     = t_op'(i_s_axis_tuser);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_ram_we = w_accept && (w_op == OP_LOAD_A);
    assign w_load_b = w_accept && (w_op == OP_LOAD_B);

    assign w_ac    = eff_dim(r_a_cols);
    assign w_br    = eff_dim(r_b_rows);
    assign w_ar_m1 = DIM_W'(eff_dim(r_a_rows) - 1'b1);
    assign w_ac_m1 = DIM_W'(w_ac - 1'b1);
    assign w_bc_m1 = DIM_W'(eff_dim(r_b_cols) - 1'b1);

    // Configuration registers.
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows <= CFG_W'(1);
            r_a_cols <= CFG_W'(1);
            r_b_rows <= CFG_W'(1);
            r_b_cols <= CFG_W'(1);
        end else if (w_cfg_we) begin
            case (t_reg'(paddr[3:2]))
                REG_A_ROWS: r_a_rows <= pwdata[CFG_W-1:0];
                REG_A_COLS: r_a_cols <= pwdata[CFG_W-1:0];
                REG_B_ROWS: r_b_rows <= pwdata[CFG_W-1:0];
                REG_B_COLS: r_b_cols <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (t_reg'(paddr[3:2]))
            REG_A_ROWS: prdata[CFG_W-1:0] = r_a_rows;
            REG_A_COLS: prdata[CFG_W-1:0] = r_a_cols;
            REG_B_ROWS: prdata[CFG_W-1:0] = r_b_rows;
            REG_B_COLS: prdata[CFG_W-1:0] = r_b_cols;
            default: prdata = '0;
        endcase
    end

    // Matrix A store.
    mme_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_a_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr ({w_row, w_col}),
        .i_wdata (w_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_raddr = {r_i, r_k};

    // The RAM read data lines up with the token fields registered beside it.
    assign w_tok[0] = '{valid: r_fvalid, first: r_ffirst, k: r_fk, a: w_rdata};

    for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
        mme_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .i_we    (w_load_b && (w_col == DIM_W'(g))),
            .i_waddr (w_row),
            .i_wdata (w_value),
            .o_acc   (w_acc[g])
        );
    end

    assign w_res      = round_sat(w_acc[r_j]);
    assign w_out_free = !r_ov || i_m_axis_tready;

    always_comb begin
        n_state  = r_state;
        n_i      = r_i;
        n_k      = r_k;
        n_j      = r_j;
        n_drain  = r_drain;
        n_fvalid = 1'b0;
        n_ffirst = 1'b0;
        n_fk     = r_k;
        n_ov     = r_ov && !i_m_axis_tready;
        n_orow   = r_orow;
        n_ocol   = r_ocol;
        n_oprod  = r_oprod;
        n_olast  = r_olast;
        n_oerr   = r_oerr;
        n_osat   = r_osat;
        o_s_axis_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (w_accept && (w_op == OP_COMPUTE)) begin
                    if (w_ac != w_br) begin
                        n_state = S_ERR;
                    end else begin
                        n_state = S_FEED;
                        n_i     = '0;
                        n_k     = '0;
                    end
                end
            end
            S_FEED: begin
                n_fvalid = 1'b1;
                n_ffirst = (r_k == '0);
                n_fk     = r_k;
                if (r_k == w_ac_m1) begin
                    n_state = S_DRAIN;
                    n_drain = '0;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_DRAIN: begin
                if (r_drain == DRAIN_W'(DRAIN_CYC - 1)) begin
                    n_state = S_OUT;
                    n_j     = '0;
                end else begin
                    n_drain = r_drain + 1'b1;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_orow  = r_i;
                    n_ocol  = r_j;
                    n_oprod = w_res.val;
                    n_osat  = w_res.sat;
                    n_oerr  = 1'b0;
                    n_olast = (r_i == w_ar_m1) && (r_j == w_bc_m1);
                    if (r_j == w_bc_m1) begin
                        if (r_i == w_ar_m1) begin
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_FEED;
                            n_i     = r_i + 1'b1;
                            n_k     = '0;
                        end
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            S_ERR: begin
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_orow  = '0;
                    n_ocol  = '0;
                    n_oprod = '0;
                    n_osat  = 1'b0;
                    n_oerr  = 1'b1;
                    n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_i      <= '0;
            r_k      <= '0;
            r_j      <= '0;
            r_drain  <= '0;
            r_fvalid <= 1'b0;
            r_ffirst <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_i      <= n_i;
            r_k      <= n_k;
            r_j      <= n_j;
            r_drain  <= n_drain;
            r_fvalid <= n_fvalid;
            r_ffirst <= n_ffirst;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fk    <= n_fk;
        r_orow  <= n_orow;
        r_ocol  <= n_ocol;
        r_oprod <= n_oprod;
        r_olast <= n_olast;
        r_oerr  <= n_oerr;
        r_osat  <= n_osat;
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {2'b00, r_oprod, r_ocol, r_orow};
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tuser  = {r_osat, r_oerr};

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> o_m_axis_tlast)
        else $error("size error transfer without tlast");

    a_tok_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[0].valid |-> (r_state == S_FEED || r_state == S_DRAIN))
        else $error("cell token outside a row run");

    a_sat_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |->
        (r_oprod == 16'sh7fff || r_oprod == 16'sh8000))
        else $error("saturated flag on unclipped product");

    a_no_new_item_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FEED || r_state == S_DRAIN || r_state == S_OUT) |-> !o_s_axis_tready)
        else $error("item taken during a compute");
endmodule
